>>> hw/rtl/gyro_bias_calibrate_and_correct_assert.svh
// Assertion macros for the gyro bias calibration block.
`ifndef GYRO_BIAS_CALIBRATE_AND_CORRECT_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_AND_CORRECT_ASSERT_SVH

`ifndef SYNTHESIS
`define GBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbc assertion failed");
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbc assertion failed");
`else
`define GBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/gbc_pkg.sv
// Types, constants and state codes shared by the gyro bias calibration block.
package gbc_pkg;

    localparam int MAX_CAL_SAMPLES_DEF = 1024;
    localparam int FRACTION_BITS_DEF   = 8;

    localparam int RAW_W     = 16;
    localparam int RATE_W    = 25;
    localparam int OFF_W     = 24;
    localparam int STATUS_W  = 2;
    localparam int CAL_W     = 11;
    localparam int DISP_W    = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic [CAL_W-1:0]  CAL_COUNT_RST = CAL_W'(200);
    localparam logic [DISP_W-1:0] DISP_MAX_RST  = DISP_W'(131);

    typedef enum logic [0:0] {
        REG_CAL_COUNT = 1'b0,
        REG_DISP_MAX  = 1'b1
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_MEAS   = 2'd0,
        ST_PROG   = 2'd1,
        ST_ACCEPT = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_CHECK,
        S_DIVIDE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                    kind;
        logic signed [RAW_W-1:0] raw_sample;
    } t_in;

    typedef struct packed {
        logic signed [RATE_W-1:0] corrected_rate;
        logic [STATUS_W-1:0]      status;
        logic signed [OFF_W-1:0]  offset_now;
    } t_out;

    typedef struct packed {
        logic    capture;
        logic    accum;
        logic    div_start;
        logic    emit;
        t_status code;
        logic    load_offset;
        logic    clear_run;
    } t_cmd;

    typedef struct packed {
        logic is_cal;
        logic run_end;
        logic spread_bad;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> hw/rtl/gyro_bias_calibrate_and_correct.sv
// Top level of the gyro Z zero-rate bias calibration and correction block.
//
// Input channel (i_valid / o_stall, payload i_data) takes one raw sample per
// beat, flagged as measurement or calibration. Output channel (o_valid /
// i_stall, payload o_data) returns exactly one result beat per input beat.
// Config registers are written through i_cfg_valid / o_cfg_ready, which is
// always ready; write only while the block is idle.
// After taking an input beat the block holds o_stall high until its result
// is in the output register; it then returns to idle for the next beat.
// The last sample of an accepted calibration run adds the serial divider,
// which yields one quotient bit per cycle.
// A finished result sits in an output register, so a new input beat is
// taken while it waits; a further result waits in the controller until the
// receiver drops i_stall. Reset clears the offset and the run statistics and
// loads cal_count = 200, dispersion_max = 131.
`include "gyro_bias_calibrate_and_correct_assert.svh"

module gyro_bias_calibrate_and_correct #(
    parameter int MAX_CAL_SAMPLES = gbc_pkg::MAX_CAL_SAMPLES_DEF,
    parameter int FRACTION_BITS   = gbc_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  gbc_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output gbc_pkg::t_out                  o_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  gbc_pkg::t_cfg_reg              i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gbc_pkg::t_cmd  w_cmd;
    gbc_pkg::t_stat w_stat;
    logic           w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    gbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gbc_datapath #(
        .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_data      (o_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

    `GBC_ASSERT_IMPLIES(a_emit_only_when_free, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free)
    `GBC_ASSERT_IMPLIES(a_div_start_idle, i_clk, i_rst_n, w_cmd.div_start, w_stat.div_done)
    `GBC_ASSERT_IMPLIES(a_offset_with_emit, i_clk, i_rst_n, w_cmd.load_offset, w_cmd.emit)
    `GBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

>>> hw/rtl/gbc_ctrl.sv
// Sequencing state machine for the gyro bias calibration block.
module gbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gbc_pkg::t_stat i_stat,
    output gbc_pkg::t_cmd  o_cmd
);

    gbc_pkg::t_state r_state;
    gbc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gbc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = gbc_pkg::S_ACCUM;
                end
            end
            gbc_pkg::S_ACCUM: begin
                n_state = gbc_pkg::S_CHECK;
            end
            gbc_pkg::S_CHECK: begin
                if (i_stat.is_cal && i_stat.run_end && !i_stat.spread_bad) begin
                    n_state = gbc_pkg::S_DIVIDE;
                end else if (i_stat.out_free) begin
                    n_state = gbc_pkg::S_IDLE;
                end
            end
            gbc_pkg::S_DIVIDE: begin
                if (i_stat.div_done) begin
                    n_state = gbc_pkg::S_FINISH;
                end
            end
            gbc_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = gbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gbc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.code = gbc_pkg::ST_MEAS;
        o_stall = 1'b1;
        case (r_state)
            gbc_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            gbc_pkg::S_ACCUM: begin
                o_cmd.accum = 1'b1;
            end
            gbc_pkg::S_CHECK: begin
                if (i_stat.is_cal && i_stat.run_end && !i_stat.spread_bad) begin
                    o_cmd.div_start = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_stat.is_cal) begin
                        o_cmd.code = gbc_pkg::ST_MEAS;
                    end else if (i_stat.run_end) begin
                        o_cmd.code      = gbc_pkg::ST_REJECT;
                        o_cmd.clear_run = 1'b1;
                    end else begin
                        o_cmd.code = gbc_pkg::ST_PROG;
                    end
                end
            end
            gbc_pkg::S_DIVIDE: begin
                o_stall = 1'b1;
            end
            gbc_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.code        = gbc_pkg::ST_ACCEPT;
                    o_cmd.load_offset = 1'b1;
                    o_cmd.clear_run   = 1'b1;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/gbc_datapath.sv
// Datapath: config registers, run statistics, serial divider and output register.
module gbc_datapath #(
    parameter int MAX_CAL_SAMPLES = gbc_pkg::MAX_CAL_SAMPLES_DEF,
    parameter int FRACTION_BITS   = gbc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbc_pkg::t_in                      i_data,
    input  logic                              i_cfg_we,
    input  gbc_pkg::t_cfg_reg                 i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  gbc_pkg::t_cmd                     i_cmd,
    output gbc_pkg::t_stat                    o_stat,
    output gbc_pkg::t_out                     o_data,
    output logic                              o_valid,
    input  logic                              i_stall
);

    localparam int RAW_W  = gbc_pkg::RAW_W;
    localparam int OFF_W  = gbc_pkg::OFF_W;
    localparam int RATE_W = gbc_pkg::RATE_W;
    localparam int CAL_W  = gbc_pkg::CAL_W;
    localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SUM_W  = RAW_W + $clog2(MAX_CAL_SAMPLES);
    localparam int DIV_W  = SUM_W + FRACTION_BITS;
    localparam int QW     = DIV_W + 1;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int TW     = (CNT_W > CAL_W) ? CNT_W : CAL_W;
    localparam int SP_W   = RAW_W + 1;
    localparam int RW     = ((RAW_W + FRACTION_BITS > OFF_W) ? RAW_W + FRACTION_BITS : OFF_W) + 1;
    localparam int CW     = (QW > OFF_W) ? QW : OFF_W;

    localparam logic signed [RW-1:0] L_RMAX = RW'((64'sd1 <<< (RATE_W - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] L_RMIN = RW'(-(64'sd1 <<< (RATE_W - 1)));
    localparam logic signed [CW-1:0] L_OMAX = CW'((64'sd1 <<< (OFF_W - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] L_OMIN = CW'(-(64'sd1 <<< (OFF_W - 1)));

    logic [CAL_W-1:0]                r_cal_count;
    logic [gbc_pkg::DISP_W-1:0]      r_disp_max;
    gbc_pkg::t_in                    r_in;
    logic signed [OFF_W-1:0]         r_offset;
    logic signed [SUM_W-1:0]         r_sum;
    logic signed [RAW_W-1:0]         r_min;
    logic signed [RAW_W-1:0]         r_max;
    logic [CNT_W-1:0]                r_cnt;
    logic [DIV_W-1:0]                r_quo;
    logic [CNT_W-1:0]                r_rem;
    logic [STEP_W-1:0]               r_step;
    gbc_pkg::t_out                   r_out;
    logic                            r_out_valid;

    logic signed [SUM_W-1:0]         w_raw_ext;
    logic [TW-1:0]                   w_cal_ext;
    logic [TW-1:0]                   w_target;
    logic signed [SP_W-1:0]          w_spread;
    logic [SUM_W-1:0]                w_mag;
    logic [CNT_W:0]                  w_trial;
    logic                            w_qbit;
    logic signed [QW-1:0]            w_q;
    logic signed [CW-1:0]            w_q_ext;
    logic signed [OFF_W-1:0]         w_off_new;
    logic signed [RW-1:0]            w_rate_full;
    logic signed [RATE_W-1:0]        w_rate;

    assign w_raw_ext = SUM_W'($signed(r_in.raw_sample));
    assign w_cal_ext = TW'(r_cal_count);
    assign w_target  = (w_cal_ext == '0) ? TW'(1) :
                       (w_cal_ext > TW'(MAX_CAL_SAMPLES)) ? TW'(MAX_CAL_SAMPLES) : w_cal_ext;
    assign w_spread  = SP_W'(r_max) - SP_W'(r_min);
    assign w_mag     = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_cnt});

    assign w_q       = r_sum[SUM_W-1] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_q_ext   = CW'(w_q);
    assign w_off_new = (w_q_ext > L_OMAX) ? OFF_W'(L_OMAX) :
                       (w_q_ext < L_OMIN) ? OFF_W'(L_OMIN) : OFF_W'(w_q_ext);

    assign w_rate_full = (RW'($signed(r_in.raw_sample)) <<< FRACTION_BITS) - RW'(r_offset);
    assign w_rate      = (w_rate_full > L_RMAX) ? RATE_W'(L_RMAX) :
                         (w_rate_full < L_RMIN) ? RATE_W'(L_RMIN) : RATE_W'(w_rate_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count <= gbc_pkg::CAL_COUNT_RST;
            r_disp_max  <= gbc_pkg::DISP_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gbc_pkg::REG_CAL_COUNT: r_cal_count <= i_cfg_data[CAL_W-1:0];
                gbc_pkg::REG_DISP_MAX:  r_disp_max  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_min <= '0;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_cmd.clear_run) begin
            r_sum <= '0;
            r_min <= '0;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accum && r_in.kind) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == '0) begin
                r_sum <= w_raw_ext;
                r_min <= r_in.raw_sample;
                r_max <= r_in.raw_sample;
            end else begin
                r_sum <= r_sum + w_raw_ext;
                if (r_in.raw_sample < r_min) begin
                    r_min <= r_in.raw_sample;
                end
                if (r_in.raw_sample > r_max) begin
                    r_max <= r_in.raw_sample;
                end
            end
        end
    end

    // restoring divide of |sum| << FRACTION_BITS by the sample count, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div_start) begin
            r_step <= STEP_W'(DIV_W);
        end else if (r_step != '0) begin
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= DIV_W'(w_mag) << FRACTION_BITS;
            r_rem <= '0;
        end else if (r_step != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], w_qbit};
            r_rem <= w_qbit ? CNT_W'(w_trial - {1'b0, r_cnt}) : CNT_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cmd.load_offset) begin
            r_offset <= w_off_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.corrected_rate <= (i_cmd.code == gbc_pkg::ST_MEAS) ? w_rate : '0;
            r_out.status         <= gbc_pkg::STATUS_W'(i_cmd.code);
            r_out.offset_now     <= i_cmd.load_offset ? w_off_new : r_offset;
        end
    end

    assign o_stat.is_cal     = r_in.kind;
    assign o_stat.run_end    = (TW'(r_cnt) >= w_target);
    assign o_stat.spread_bad = (w_spread > $signed({1'b0, r_disp_max}));
    assign o_stat.div_done   = (r_step == '0);
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    assign o_data  = r_out;
    assign o_valid = r_out_valid;

endmodule

>>> bench/gbc_rate_checker.sv
`timescale 1ns / 1ps
// Beat checker for the gyro bias block: predicts every result beat and compares it field by field.
module gbc_rate_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  gbc_pkg::t_in                   i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  gbc_pkg::t_out                  i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  gbc_pkg::t_cfg_reg              i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_results,
    output int                             o_runs_accepted,
    output int                             o_runs_rejected
);
    import gbc_pkg::*;

    localparam int     FRAC    = FRACTION_BITS_DEF;
    localparam longint RATE_HI = (longint'(1) <<< (RATE_W - 1)) - 1;
    localparam longint RATE_LO = -(longint'(1) <<< (RATE_W - 1));
    localparam longint OFF_HI  = (longint'(1) <<< (OFF_W - 1)) - 1;
    localparam longint OFF_LO  = -(longint'(1) <<< (OFF_W - 1));

    logic [CAL_W-1:0]         cal_count;
    logic [DISP_W-1:0]        disp_max;
    logic signed [OFF_W-1:0]  zero_offset;
    logic signed [26:0]       run_sum;
    logic signed [RAW_W-1:0]  run_min;
    logic signed [RAW_W-1:0]  run_max;
    logic [CAL_W-1:0]         run_len;

    t_out rate_queue[$];
    int   fail_total;
    int   outstanding;
    int   results_seen;
    int   runs_accepted;
    int   runs_rejected;

    assign o_fail_count    = fail_total;
    assign o_outstanding   = outstanding;
    assign o_results       = results_seen;
    assign o_runs_accepted = runs_accepted;
    assign o_runs_rejected = runs_rejected;

    function automatic t_out correct_sample(t_in s);
        t_out   r;
        int     target;
        int     spread;
        longint q;
        longint rate;
        r = '0;
        if (s.kind == 1'b0) begin
            rate = (longint'(s.raw_sample) <<< FRAC) - longint'(zero_offset);
            rate = (rate > RATE_HI) ? RATE_HI : ((rate < RATE_LO) ? RATE_LO : rate);
            r.corrected_rate = rate[RATE_W-1:0];
            r.status = ST_MEAS;
        end else begin
            target = int'(cal_count);
            if (target == 0) target = 1;
            if (target > MAX_CAL_SAMPLES_DEF) target = MAX_CAL_SAMPLES_DEF;
            if (run_len == '0) begin
                run_sum = 27'(s.raw_sample);
                run_min = s.raw_sample;
                run_max = s.raw_sample;
            end else begin
                run_sum = run_sum + 27'(s.raw_sample);
                if (s.raw_sample < run_min) run_min = s.raw_sample;
                if (s.raw_sample > run_max) run_max = s.raw_sample;
            end
            run_len = run_len + CAL_W'(1);
            if (int'(run_len) >= target) begin
                spread = int'(run_max) - int'(run_min);
                if (spread > int'(disp_max)) begin
                    r.status = ST_REJECT;
                    runs_rejected++;
                end else begin
                    // truncates toward zero, as the offset does
                    q = (longint'(run_sum) <<< FRAC) / longint'(run_len);
                    q = (q > OFF_HI) ? OFF_HI : ((q < OFF_LO) ? OFF_LO : q);
                    zero_offset = q[OFF_W-1:0];
                    r.status = ST_ACCEPT;
                    runs_accepted++;
                end
                run_sum = '0;
                run_min = '0;
                run_max = '0;
                run_len = '0;
            end else begin
                r.status = ST_PROG;
            end
        end
        r.offset_now = zero_offset;
        return r;
    endfunction

    function automatic void note_mismatch(string field, longint want, longint got);
        fail_total++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin
        int   delta;
        t_out want;
        delta = 0;
        if (!i_rst_n) begin
            cal_count     = CAL_COUNT_RST;
            disp_max      = DISP_MAX_RST;
            zero_offset   = '0;
            run_sum       = '0;
            run_min       = '0;
            run_max       = '0;
            run_len       = '0;
            rate_queue.delete();
            fail_total    = 0;
            results_seen  = 0;
            runs_accepted = 0;
            runs_rejected = 0;
            outstanding  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CAL_COUNT: cal_count = i_cfg_data[CAL_W-1:0];
                    REG_DISP_MAX:  disp_max  = i_cfg_data[DISP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (rate_queue.size() == 0) begin
                    fail_total++;
                    $display("%0t: result beat with none expected, expected nothing, actual %h",
                             $time, i_out_data);
                end else begin
                    want = rate_queue.pop_front();
                    delta--;
                    results_seen++;
                    if (want.corrected_rate !== i_out_data.corrected_rate)
                        note_mismatch("corrected_rate", longint'(want.corrected_rate),
                                      longint'(i_out_data.corrected_rate));
                    if (want.status !== i_out_data.status)
                        note_mismatch("status", longint'(want.status),
                                      longint'(i_out_data.status));
                    if (want.offset_now !== i_out_data.offset_now)
                        note_mismatch("offset_now", longint'(want.offset_now),
                                      longint'(i_out_data.offset_now));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rate_queue.push_back(correct_sample(i_in_data));
                delta++;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

>>> bench/tb_gyro_bias_calibrate_and_correct.sv
`timescale 1ns / 1ps
// Testbench top for the gyro bias block: clock, reset, sample and register stimulus, verdict.
module tb_gyro_bias_calibrate_and_correct;
    import gbc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in                   i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_reg              i_cfg_index = REG_CAL_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int   fail_count;
    int   outstanding;
    int   results;
    int   runs_accepted;
    int   runs_rejected;

    int   send_idle_pct = 15;
    int   recv_idle_pct = 87;
    logic stall_hold = 1'b0;
    logic pressure_go = 1'b0;
    int   quiet_cycles = 0;
    int   sent_count = 0;
    int   cur_cal = 200;
    int   cur_disp = 131;

    gyro_bias_calibrate_and_correct dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gbc_rate_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_data       (i_data),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_data      (o_data),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_results       (results),
        .o_runs_accepted (runs_accepted),
        .o_runs_rejected (runs_rejected)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // long output hold-off so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic signed [RAW_W-1:0] random_raw();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic int run_length();
        if (cur_cal == 0) return 1;
        if (cur_cal > MAX_CAL_SAMPLES_DEF) return MAX_CAL_SAMPLES_DEF;
        return cur_cal;
    endfunction

    task automatic push_sample(input logic kind, input logic signed [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{kind: kind, raw_sample: raw};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_CAL_COUNT) cur_cal = value;
        else cur_disp = value;
    endtask

    task automatic configure(input int cal, input int disp);
        settle();
        write_reg(REG_CAL_COUNT, cal);
        write_reg(REG_DISP_MAX, disp);
    endtask

    task automatic run_calibration(input int len, input bit narrow, input int meas_pct);
        int centre;
        int width;
        int v;
        centre = int'(random_raw());
        width  = $urandom_range(0, (cur_disp > 300) ? 300 : cur_disp);
        for (int i = 0; i < len; i++) begin
            if (narrow) begin
                v = centre + int'($urandom_range(0, width));
                push_sample(1'b1, RAW_W'((v > 32767) ? 32767 : v));
            end else begin
                push_sample(1'b1, random_raw());
            end
            if ($urandom_range(99) < meas_pct) push_sample(1'b0, random_raw());
        end
    endtask

    task automatic random_phase(input int n_items);
        int start;
        start = sent_count;
        while (sent_count - start < n_items) begin
            if ($urandom_range(99) < 55)
                run_calibration(run_length(), $urandom_range(99) < 75, 25);
            else
                push_sample(1'b0, random_raw());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, single-sample runs, threshold edges
        configure(1, 0);
        push_sample(1'b0, 16'sd0);
        push_sample(1'b0, 16'sh7fff);
        push_sample(1'b0, 16'sh8000);
        push_sample(1'b0, -16'sd1);
        push_sample(1'b1, 16'sh7fff);
        push_sample(1'b0, 16'sh8000);
        push_sample(1'b0, 16'sh7fff);
        push_sample(1'b1, 16'sh8000);
        push_sample(1'b0, 16'sh7fff);
        configure(3, 10);
        push_sample(1'b1, 16'sd100);
        push_sample(1'b0, 16'sd5);
        push_sample(1'b1, 16'sd110);
        push_sample(1'b1, 16'sd105);
        push_sample(1'b1, 16'sd0);
        push_sample(1'b1, 16'sd11);
        push_sample(1'b1, 16'sd5);
        push_sample(1'b1, -16'sd1);
        push_sample(1'b1, -16'sd1);
        push_sample(1'b1, -16'sd2);
        push_sample(1'b1, 16'sd7);
        push_sample(1'b1, 16'sd9);
        settle();
        write_reg(REG_CAL_COUNT, 1);
        push_sample(1'b1, 16'sd8);
        configure(0, 65535);
        push_sample(1'b1, 16'sd1234);
        configure(2, 65535);
        push_sample(1'b1, 16'sh8000);
        push_sample(1'b1, 16'sh7fff);
        push_sample(1'b0, 16'sd0);

        configure(4, 131);
        random_phase(130);
        configure(1, 0);
        random_phase(80);
        configure(0, 65535);
        random_phase(50);

        send_idle_pct = 87;
        recv_idle_pct = 15;
        configure(16, 500);
        random_phase(160);
        configure(7, 20);
        random_phase(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(2047, 300);
        pressure_go = 1'b1;
        run_calibration(120, 1'b1, 0);
        configure(3, 65535);
        random_phase(200);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d sample beats checked; %0d calibration runs accepted, %0d rejected",
                 results, runs_accepted, runs_rejected);
        $display("Run lengths 0 to 2047, thresholds 0 to 65535, three idle mixes, one long hold-off");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> gyro_bias_calibrate_and_correct.f
+incdir+hw/rtl
hw/rtl/gbc_pkg.sv
hw/rtl/gbc_ctrl.sv
hw/rtl/gbc_datapath.sv
hw/rtl/gyro_bias_calibrate_and_correct.sv
bench/gbc_rate_checker.sv
bench/tb_gyro_bias_calibrate_and_correct.sv
